// ----- rtl/bit_field_pack_unpack_buffer_unit_assert.svh -----
// Assertion macros for the bit field pack/unpack buffer.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef BIT_FIELD_PACK_UNPACK_BUFFER_UNIT_ASSERT_SVH
`define BIT_FIELD_PACK_UNPACK_BUFFER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define BFPU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfpu: same-cycle check failed");
// Next-cycle implication
`define BFPU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfpu: next-cycle check failed");
`else
`define BFPU_ASSERT_IMP(label, ante, cons)
`define BFPU_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- rtl/bfpu_pkg.sv -----
// Shared constants, codes and types of the bit field pack/unpack buffer.
// No dependencies; used by the top level bit_field_pack_unpack_buffer_unit.
`default_nettype none

package bfpu_pkg;

  // Store geometry
  localparam int BUF_BYTES = 512;
  localparam int CAP_BITS  = BUF_BYTES * 8;
  localparam int ADDR_W    = $clog2(BUF_BYTES);
  localparam int POS_W     = $clog2(CAP_BITS) + 1;

  // Field widths
  localparam int CMD_W  = 3;
  localparam int LEN_W  = 6;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int MAX_LEN = 32;

  // Stream packing
  localparam int IN_RAW_W    = LEN_W + VAL_W + POS_W;
  localparam int IN_TDATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W   = VAL_W + 2 * POS_W;
  localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int IN_LEN_LSB  = 0;
  localparam int IN_VAL_LSB  = LEN_W;
  localparam int IN_POS_LSB  = LEN_W + VAL_W;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ALIGN = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SETPOS = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_PAST_WL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DROPPED = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_XFER  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/bit_field_pack_unpack_buffer_unit.sv -----
// Bit field pack/unpack buffer: top level with command sequencer and byte store.
// Depends on bfpu_pkg, bfpu_ram and bit_field_pack_unpack_buffer_unit_assert.svh.
//
// Usage:
//   Requests enter on the s_ channel (s_tuser = command), one result per request
//   leaves on the m_ channel (m_tuser = status). A request is taken when s_tvalid
//   and s_tready are both high; one request is worked on at a time.
//   Write and read fields move one byte-sized chunk per cycle through a 32-bit
//   shift register; a write chunk is a read-modify-write of one byte of the
//   store, a read chunk a read of one byte. A field touching n bytes (0 to 5)
//   passes through accept, n chunk steps and result load before the next
//   request; align, set position and unused commands go from accept straight
//   to result load; there the result is loaded into the output register once
//   that register is free. A clear sweeps all BUF_BYTES (512) bytes one byte
//   per cycle before its result is given; after reset the same sweep runs with
//   s_tready low and no result. If the receiver stalls, the pending result
//   stays in the output register; the next request is still accepted and
//   worked on, and its result waits in the sequencer until the register is free.
`default_nettype none
`include "bit_field_pack_unpack_buffer_unit_assert.svh"

module bit_field_pack_unpack_buffer_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // request channel
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // field_length, field_value, new_position (from bit 0 up), zero padded
  input  wire logic [bfpu_pkg::IN_TDATA_W-1:0] s_tdata,
  // command
  input  wire logic [bfpu_pkg::CMD_W-1:0]      s_tuser,
  // result channel
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // read_value, position_bits, length_bits (from bit 0 up), zero padded
  output logic [bfpu_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // status
  output logic [bfpu_pkg::STAT_W-1:0]          m_tuser
);
  import bfpu_pkg::*;

  localparam logic [POS_W:0]    CAP_EXT   = (POS_W+1)'(CAP_BITS);
  localparam logic [POS_W-1:0]  CAP_POS   = POS_W'(CAP_BITS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BUF_BYTES - 1);
  localparam int                OUT_PAD_W = OUT_TDATA_W - OUT_RAW_W;

  // registers
  state_t             state, state_next;
  logic [POS_W-1:0]   bit_position, bit_position_next;
  logic [POS_W-1:0]   written_length, written_length_next;
  logic [LEN_W-1:0]   rem, rem_next;
  logic [VAL_W-1:0]   shreg, shreg_next;
  logic               is_write, is_write_next;
  logic               is_rd, is_rd_next;
  logic [STAT_W-1:0]  res_status, res_status_next;
  logic [ADDR_W-1:0]  clr_addr, clr_addr_next;
  logic               clr_reply, clr_reply_next;

  // request decode
  logic [LEN_W-1:0]   len_raw, len_c;
  logic [VAL_W-1:0]   in_value;
  logic [POS_W-1:0]   in_newpos;
  logic [POS_W:0]     end_pos;
  logic [POS_W-1:0]   aligned;

  // chunk datapath
  logic [2:0]         off;
  logic [3:0]         avail, count;
  logic [7:0]         mask8, chunk, merged, rd_bits, rdata;
  logic               load_out;

  // store port
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [7:0]         ram_wdata;

  assign s_tready = (state == ST_IDLE);

  // unpack the request
  assign len_raw   = s_tdata[IN_LEN_LSB +: LEN_W];
  assign in_value  = s_tdata[IN_VAL_LSB +: VAL_W];
  assign in_newpos = s_tdata[IN_POS_LSB +: POS_W];
  assign len_c     = (len_raw > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len_raw;
  assign end_pos   = {1'b0, bit_position} + (POS_W+1)'(len_c);
  assign aligned   = bit_position + POS_W'(7);

  // one chunk: never crosses a byte, at most the bits still to move
  assign off     = bit_position[2:0];
  assign avail   = 4'd8 - {1'b0, off};
  assign count   = (rem < LEN_W'(avail)) ? rem[3:0] : avail;
  assign mask8   = (8'hFF >> (4'd8 - count)) << off;
  assign chunk   = shreg[VAL_W-1 -: 8] >> (4'd8 - count);
  assign merged  = (rdata & ~mask8) | ((chunk << off) & mask8);
  assign rd_bits = (rdata & mask8) >> off;

  // sequencer
  always_comb begin
    state_next          = state;
    bit_position_next   = bit_position;
    written_length_next = written_length;
    rem_next            = rem;
    shreg_next          = shreg;
    is_write_next       = is_write;
    is_rd_next          = is_rd;
    res_status_next     = res_status;
    clr_addr_next       = clr_addr;
    clr_reply_next      = clr_reply;
    ram_we              = 1'b0;
    ram_waddr           = bit_position[ADDR_W+2:3];
    ram_wdata           = merged;
    load_out            = 1'b0;

    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == LAST_ADDR) begin
          state_next     = clr_reply ? ST_DONE : ST_IDLE;
          clr_reply_next = 1'b0;
        end else begin
          clr_addr_next = clr_addr + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          res_status_next = STAT_OK;
          is_rd_next      = 1'b0;
          state_next      = ST_DONE;
          case (s_tuser)
            CMD_WRITE: begin
              if (end_pos > CAP_EXT) begin
                res_status_next = STAT_DROPPED;
              end else if (len_c != '0) begin
                is_write_next = 1'b1;
                rem_next      = len_c;
                shreg_next    = in_value << (LEN_W'(VAL_W) - len_c);
                state_next    = ST_XFER;
              end
            end
            CMD_READ: begin
              if (end_pos > CAP_EXT) begin
                res_status_next = STAT_DROPPED;
              end else begin
                if (end_pos > {1'b0, written_length}) begin
                  res_status_next = STAT_PAST_WL;
                end
                is_rd_next    = 1'b1;
                is_write_next = 1'b0;
                rem_next      = len_c;
                shreg_next    = '0;
                if (len_c != '0) begin
                  state_next = ST_XFER;
                end
              end
            end
            CMD_ALIGN: begin
              bit_position_next = {aligned[POS_W-1:3], 3'b000};
            end
            CMD_SETPOS: begin
              if (in_newpos > CAP_POS) begin
                res_status_next = STAT_DROPPED;
              end else begin
                bit_position_next = in_newpos;
              end
            end
            CMD_CLEAR: begin
              bit_position_next   = '0;
              written_length_next = '0;
              clr_addr_next       = '0;
              clr_reply_next      = 1'b1;
              state_next          = ST_CLEAR;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_XFER: begin
        ram_we            = is_write;
        bit_position_next = bit_position + POS_W'(count);
        rem_next          = rem - LEN_W'(count);
        shreg_next        = (shreg << count) | (is_write ? '0 : VAL_W'(rd_bits));
        if (rem == LEN_W'(count)) begin
          state_next = ST_DONE;
          if (is_write && bit_position_next > written_length) begin
            written_length_next = bit_position_next;
          end
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // next byte is read while the current one is written
  assign ram_raddr = bit_position_next[ADDR_W+2:3];

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      bit_position   <= '0;
      written_length <= '0;
      clr_addr       <= '0;
      clr_reply      <= 1'b0;
    end else begin
      state          <= state_next;
      bit_position   <= bit_position_next;
      written_length <= written_length_next;
      clr_addr       <= clr_addr_next;
      clr_reply      <= clr_reply_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    rem        <= rem_next;
    shreg      <= shreg_next;
    is_write   <= is_write_next;
    is_rd      <= is_rd_next;
    res_status <= res_status_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, written_length, bit_position,
                  (is_rd ? shreg : {VAL_W{1'b0}})};
      m_tuser <= res_status;
    end
  end

  // byte store
  bfpu_ram #(
    .WIDTH (8),
    .DEPTH (BUF_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // checks
  `BFPU_ASSERT_IMP(a_within_cap, 1'b1, (bit_position <= CAP_POS) && (written_length <= CAP_POS))
  `BFPU_ASSERT_IMP(a_xfer_pending, state == ST_XFER, rem != '0)
  `BFPU_ASSERT_IMP(a_no_store_write, (state == ST_IDLE) || (state == ST_DONE), !ram_we)
  `BFPU_ASSERT_NXT(a_length_grows, (state != ST_CLEAR) && !(s_tvalid && s_tready && (s_tuser == CMD_CLEAR)), written_length >= $past(written_length))

endmodule

`default_nettype wire

// ----- rtl/bfpu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the byte store of the pack/unpack buffer.
`default_nettype none

module bfpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
